// ===== hdl/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, command codes and helper functions for the MT19937
// generator block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtg_pkg;

  // Store geometry
  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned MID_OFFSET  = 397;

  // Generator constants
  localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] MIX_MULT_A = 32'h0019_660d;
  localparam logic [31:0] MIX_MULT_B = 32'h5d58_8b65;
  localparam logic [31:0] BASE_SEED  = 32'h012b_d6aa;
  localparam logic [31:0] TOP_BIT    = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;

  // Request commands
  typedef enum logic [1:0] {
    CMD_DRAW = 2'd0,
    CMD_SEED = 2'd1,
    CMD_KEY  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Word fold used by every seeding recurrence
  function automatic logic [31:0] seed_mix(input logic [31:0] x);
    seed_mix = x ^ (x >> 30);
  endfunction

  // Output tempering
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ (x >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    temper = t ^ (t >> 18);
  endfunction

endpackage

// ===== hdl/mt19937_generator_top.sv =====
// ----------------------------------------------------------------------------
// mt19937_generator_top
// MT19937 generator with the 624-word state in a synchronous RAM, plus a
// key word RAM for array seeding.
// ----------------------------------------------------------------------------
// Draw: two read passes (current/next word, then middle word); the result is
//   registered once the output can take it, and no request is taken before.
// Seed from value: word 0 takes the value, then two steps per further word (multiply, then add).
// Key word with last mark: base seed pass, 624 + 623 mixing steps, final
//   write. Other key words are only stored in the key RAM, up to KEY_DEPTH.
// Reset: an initialization pass seeds the store with 19650218;
//   no request is accepted until it completes.
`timescale 1ns / 1ps

module mt19937_generator_top #(
  parameter int unsigned KEY_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] value_i,
  input  logic        key_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_value_o
);
  import mtg_pkg::*;

  localparam int unsigned KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(KEY_DEPTH + 1);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DR1  = 4'd1;
  localparam logic [3:0] ST_DR2  = 4'd2;
  localparam logic [3:0] ST_SS0  = 4'd3;
  localparam logic [3:0] ST_SSM  = 4'd4;
  localparam logic [3:0] ST_SSW  = 4'd5;
  localparam logic [3:0] ST_P1A  = 4'd6;
  localparam logic [3:0] ST_P1B  = 4'd7;
  localparam logic [3:0] ST_P2A  = 4'd8;
  localparam logic [3:0] ST_P2B  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] p_q, p_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [KW-1:0]    q_q, q_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    key_cnt_q, key_cnt_d;
  logic             arr_q, arr_d;
  logic             wrap_q, wrap_d;
  logic [31:0]      prev_q, prev_d;
  logic [31:0]      prod_q;
  logic [31:0]      ymix_q, ymix_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_q, out_d;

  logic [31:0]      mem [STATE_WORDS];
  logic [31:0]      rd_a_q, rd_b_q;
  logic [IDX_W-1:0] addr_a, addr_b, waddr;
  logic             we;
  logic [31:0]      wdata;

  logic [31:0]      key_mem [KEY_DEPTH];
  logic [31:0]      key_rd_q;
  logic             key_we;

  logic [IDX_W-1:0] cur, nxt, mid;
  logic [IDX_W:0]   mid_sum;
  logic [31:0]      mult_k;
  logic [31:0]      y_tw;
  logic             accept, load_ok;
  logic [CW-1:0]    key_cnt_inc;

  assign accept  = in_valid_i && in_ready_o;
  assign load_ok = !out_valid_q || out_ready_i;

  // Draw addresses
  assign cur     = pos_q;
  assign nxt     = (cur == LAST_IDX) ? '0 : cur + 1'b1;
  assign mid_sum = {1'b0, cur} + (IDX_W + 1)'(MID_OFFSET);
  assign mid     = (mid_sum >= (IDX_W + 1)'(STATE_WORDS)) ?
                   IDX_W'(mid_sum - (IDX_W + 1)'(STATE_WORDS)) : mid_sum[IDX_W-1:0];

  // Twisted word from the middle word and the saved upper/lower mix
  assign y_tw = rd_a_q ^ (ymix_q >> 1) ^ (ymix_q[0] ? MATRIX_A : 32'h0);

  // Read addresses follow the state so stalled reads repeat
  always_comb begin
    unique case (state_q)
      ST_IDLE: begin
        addr_a = cur;
        addr_b = nxt;
      end
      ST_DR1, ST_DR2: begin
        addr_a = mid;
        addr_b = nxt;
      end
      default: begin
        addr_a = p_q;
        addr_b = nxt;
      end
    endcase
  end

  // State RAM: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // Key word RAM
  assign key_we = accept && (cmd_i == CMD_KEY) && (key_cnt_q < CW'(KEY_DEPTH));

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_cnt_q[KW-1:0]] <= value_i;
    end
    key_rd_q <= key_mem[q_q];
  end

  // Shared multiplier, registered
  always_comb begin
    unique case (state_q)
      ST_P1A:  mult_k = MIX_MULT_A;
      ST_P2A:  mult_k = MIX_MULT_B;
      default: mult_k = INIT_MULT;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 32'(seed_mix(prev_q) * mult_k);
  end

  // Sequencer and write port
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    p_d         = p_q;
    k_d         = k_q;
    q_d         = q_q;
    len_d       = len_q;
    key_cnt_d   = key_cnt_q;
    arr_d       = arr_q;
    wrap_d      = wrap_q;
    prev_d      = prev_q;
    ymix_d      = ymix_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = p_q;
    wdata       = 32'h0;
    key_cnt_inc = key_cnt_q + 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_DRAW: state_d = ST_DR1;
            CMD_SEED: begin
              prev_d  = value_i;
              arr_d   = 1'b0;
              state_d = ST_SS0;
            end
            CMD_KEY: begin
              if (key_cnt_q < CW'(KEY_DEPTH)) begin
                key_cnt_d = key_cnt_inc;
              end
              if (key_last_i) begin
                // Length of the key, the last word included and capped at KEY_DEPTH
                if (key_cnt_q < CW'(KEY_DEPTH)) begin
                  len_d = key_cnt_inc;
                end else begin
                  len_d = key_cnt_q;
                end
                key_cnt_d = '0;
                prev_d    = BASE_SEED;
                arr_d     = 1'b1;
                state_d   = ST_SS0;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DR1: begin
        ymix_d  = (rd_a_q & TOP_BIT) | (rd_b_q & LOW_BITS);
        state_d = ST_DR2;
      end
      ST_DR2: begin
        if (load_ok) begin
          we          = 1'b1;
          waddr       = cur;
          wdata       = y_tw;
          out_d       = temper(y_tw);
          out_valid_d = 1'b1;
          pos_d       = nxt;
          state_d     = ST_IDLE;
        end
      end
      ST_SS0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = prev_q;
        p_d     = IDX_W'(1);
        state_d = ST_SSM;
      end
      ST_SSM: state_d = ST_SSW;
      ST_SSW: begin
        we     = 1'b1;
        wdata  = prod_q + 32'(p_q);
        prev_d = wdata;
        if (p_q == LAST_IDX) begin
          pos_d = '0;
          if (arr_q) begin
            // Mixing starts from word 0, which holds the base seed
            prev_d  = BASE_SEED;
            p_d     = IDX_W'(1);
            q_d     = '0;
            k_d     = LAST_IDX;
            wrap_d  = 1'b0;
            state_d = ST_P1A;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          p_d     = p_q + 1'b1;
          state_d = ST_SSM;
        end
      end
      ST_P1A, ST_P2A: begin
        // Deferred copy of the last word into word 0 after a wrap
        if (wrap_q) begin
          we     = 1'b1;
          waddr  = '0;
          wdata  = prev_q;
          wrap_d = 1'b0;
        end
        state_d = (state_q == ST_P1A) ? ST_P1B : ST_P2B;
      end
      ST_P1B, ST_P2B: begin
        we = 1'b1;
        if (state_q == ST_P1B) begin
          wdata = (rd_a_q ^ prod_q) + key_rd_q + 32'(q_q);
        end else begin
          wdata = (rd_a_q ^ prod_q) - 32'(p_q);
        end
        prev_d = wdata;
        if (p_q == LAST_IDX) begin
          p_d    = IDX_W'(1);
          wrap_d = 1'b1;
        end else begin
          p_d = p_q + 1'b1;
        end
        if (CW'(q_q) + 1'b1 >= len_q) begin
          q_d = '0;
        end else begin
          q_d = q_q + 1'b1;
        end
        k_d = k_q - 1'b1;
        if (k_q == '0) begin
          if (state_q == ST_P1B) begin
            k_d     = LAST_IDX - 1'b1;
            state_d = ST_P2A;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = (state_q == ST_P1B) ? ST_P1A : ST_P2A;
        end
      end
      ST_FIN: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = TOP_BIT;
        wrap_d  = 1'b0;
        pos_d   = '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers; reset starts the base seeding pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SS0;
      pos_q       <= '0;
      p_q         <= '0;
      k_q         <= '0;
      q_q         <= '0;
      len_q       <= '0;
      key_cnt_q   <= '0;
      arr_q       <= 1'b0;
      wrap_q      <= 1'b0;
      prev_q      <= BASE_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      p_q         <= p_d;
      k_q         <= k_d;
      q_q         <= q_d;
      len_q       <= len_d;
      key_cnt_q   <= key_cnt_d;
      arr_q       <= arr_d;
      wrap_q      <= wrap_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ymix_q <= ymix_d;
    out_q  <= out_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_q;

endmodule

// ===== hdl/mtg_checker.sv =====
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks for the MT19937 generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] random_value_o
);
  import mtg_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(random_value_o))
    else $error("result changed while stalled");

  // A draw request keeps the block busy next cycle
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_DRAW) |=> !in_ready_o)
    else $error("draw request did not occupy the block");

  // A seed request starts a reseeding pass
  a_seed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_SEED) |=> !in_ready_o)
    else $error("seed request did not start reseeding");

  // A new result only appears at the end of a draw in progress
  a_out_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a draw in progress");

endmodule

bind mt19937_generator_top mtg_checker u_mtg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .cmd_i          (cmd_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .random_value_o (random_value_o)
);
